// File: sv/tlcb_pkg.sv
package tlcb_pkg;

  // Input request: pixel position and the current destination pixel.
  typedef struct packed {
    logic [10:0] pixel_col;
    logic [10:0] pixel_row;
    logic [31:0] dest_pixel;
  } in_t;

  // Result: shaded pixel, coverage flag and blend weight.
  typedef struct packed {
    logic [31:0] out_pixel;
    logic        covered;
    logic [8:0]  blend_weight;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_X      = 3'd0,
    REG_START_Y      = 3'd1,
    REG_END_X        = 3'd2,
    REG_END_Y        = 3'd3,
    REG_STROKE_WIDTH = 3'd4,
    REG_FORE_RGB     = 3'd5,
    REG_IMAGE_COLS   = 3'd6,
    REG_IMAGE_ROWS   = 3'd7
  } cfg_reg_e;

  localparam int          CFG_DATA_W   = 24;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [8:0]  FULL_WEIGHT  = 9'd256;
  localparam logic [6:0]  MIN_STROKE   = 7'd2;
  localparam int          SQRT_IN_W    = 45;
  localparam int          SQRT_STEPS   = 23;
  localparam int          T_BITS       = 16;

endpackage

// File: sv/tlcb_front.sv
module tlcb_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tlcb_pkg::in_t                in_data,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [11:0]                  image_cols,
  input  logic [11:0]                  image_rows,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [33+4*((COORD_BITS > 12 ? COORD_BITS : 12)+2)
                +4*((COORD_BITS > 12 ? COORD_BITS : 12)+2)-1:0] q_data
);
  import tlcb_pkg::*;

  localparam int PW = (COORD_BITS > 12 ? COORD_BITS : 12) + 2;
  localparam int DW = 2 * PW;

  logic        fv;
  in_t         freg;
  logic        off_img;
  logic signed [PW-1:0] colx, rowx, x0, y0, x1, y1;
  logic signed [PW-1:0] apx, apy, abx, aby;
  logic signed [DW-1:0] dot, denom;

  // Input register; it moves on whenever the queue can take what it holds.
  assign in_ready = !fv || !q_full;
  assign q_push   = fv && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      freg <= in_data;
    end
  end

  // Vectors from the segment start to the pixel position and to the segment end,
  // in half-pixel units, and the projection dot product and squared length.
  always_comb begin
    off_img = ({1'b0, freg.pixel_col} >= image_cols) ||
              ({1'b0, freg.pixel_row} >= image_rows);
    colx  = PW'(signed'({1'b0, freg.pixel_col}));
    rowx  = PW'(signed'({1'b0, freg.pixel_row}));
    x0    = PW'(start_x);
    y0    = PW'(start_y);
    x1    = PW'(end_x);
    y1    = PW'(end_y);
    apx   = (colx - x0) <<< 1;
    apy   = (rowx - y0) <<< 1;
    abx   = (x1 - x0) <<< 1;
    aby   = (y1 - y0) <<< 1;
    dot   = DW'(apx) * DW'(abx) + DW'(apy) * DW'(aby);
    denom = DW'(abx) * DW'(abx) + DW'(aby) * DW'(aby);
  end

  assign q_data = {freg.dest_pixel, off_img, apx, apy, abx, aby, dot, denom};

endmodule

// File: sv/tlcb_queue.sv
module tlcb_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] rdata
);
  import tlcb_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rptr];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: sv/tlcb_back.sv
module tlcb_back #(
  parameter int COORD_BITS = 12,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  logic [33+4*((COORD_BITS > 12 ? COORD_BITS : 12)+2)
                +4*((COORD_BITS > 12 ? COORD_BITS : 12)+2)-1:0] q_data,
  output logic                 q_pop,
  input  logic [6:0]           stroke_width,
  input  logic [23:0]          fore_rgb,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlcb_pkg::out_t       out_data
);
  import tlcb_pkg::*;

  localparam int PW = (COORD_BITS > 12 ? COORD_BITS : 12) + 2;
  localparam int DW = 2 * PW;
  localparam int XW = PW + 18;
  localparam int NS = SQRT_STEPS;
  localparam int SW = SQRT_IN_W;
  localparam logic [8:0] MAXW = 9'(MAX_WIDTH);

  logic en;

  // Fields of the queue head.
  logic [31:0]          h_dst;
  logic                 h_off;
  logic signed [PW-1:0] h_apx, h_apy, h_abx, h_aby;
  logic signed [DW-1:0] h_dot, h_den;

  assign {h_dst, h_off, h_apx, h_apy, h_abx, h_aby, h_dot, h_den} = q_data;

  // The whole back pipeline advances together when the output can move.
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_not_empty;

  // Divider segment: index 0 is the classify stage, 1..16 produce quotient bits.
  logic                 dv_v   [0:T_BITS];
  logic [31:0]          dv_dst [0:T_BITS];
  logic                 dv_off [0:T_BITS];
  logic signed [PW-1:0] dv_apx [0:T_BITS];
  logic signed [PW-1:0] dv_apy [0:T_BITS];
  logic signed [PW-1:0] dv_abx [0:T_BITS];
  logic signed [PW-1:0] dv_aby [0:T_BITS];
  logic                 dv_tz  [0:T_BITS];
  logic                 dv_to  [0:T_BITS];
  logic [DW-1:0]        dv_den [0:T_BITS];
  logic [DW-1:0]        dv_r   [0:T_BITS];
  logic [T_BITS-1:0]    dv_q   [0:T_BITS];

  // Classify: projection clamps to zero or one, otherwise divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_dst[0] <= h_dst;
      dv_off[0] <= h_off;
      dv_apx[0] <= h_apx;
      dv_apy[0] <= h_apy;
      dv_abx[0] <= h_abx;
      dv_aby[0] <= h_aby;
      dv_tz[0]  <= (h_den == '0) || h_dot[DW-1] || (h_dot == '0);
      dv_to[0]  <= (h_dot >= h_den);
      dv_den[0] <= DW'(h_den);
      dv_r[0]   <= DW'(h_dot);
      dv_q[0]   <= '0;
    end
  end

  // One restoring division step per stage.
  for (genvar k = 1; k <= T_BITS; k++) begin : g_div
    logic [DW-1:0] r2;
    logic          ge;
    always_comb begin
      r2 = {dv_r[k-1][DW-2:0], 1'b0};
      ge = (r2 >= dv_den[k-1]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= dv_v[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_dst[k] <= dv_dst[k-1];
        dv_off[k] <= dv_off[k-1];
        dv_apx[k] <= dv_apx[k-1];
        dv_apy[k] <= dv_apy[k-1];
        dv_abx[k] <= dv_abx[k-1];
        dv_aby[k] <= dv_aby[k-1];
        dv_tz[k]  <= dv_tz[k-1];
        dv_to[k]  <= dv_to[k-1];
        dv_den[k] <= dv_den[k-1];
        dv_r[k]   <= ge ? (r2 - dv_den[k-1]) : r2;
        dv_q[k]   <= {dv_q[k-1][T_BITS-2:0], ge};
      end
    end
  end

  // Projection times segment vector.
  logic [T_BITS:0]      t16;
  logic                 m1_v;
  logic [31:0]          m1_dst;
  logic                 m1_off;
  logic signed [PW-1:0] m1_apx, m1_apy;
  logic signed [XW-1:0] m1_px, m1_py;

  always_comb begin
    if (dv_tz[T_BITS]) begin
      t16 = '0;
    end else if (dv_to[T_BITS]) begin
      t16 = {1'b1, {T_BITS{1'b0}}};
    end else begin
      t16 = {1'b0, dv_q[T_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= dv_v[T_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_dst <= dv_dst[T_BITS];
      m1_off <= dv_off[T_BITS];
      m1_apx <= dv_apx[T_BITS];
      m1_apy <= dv_apy[T_BITS];
      m1_px  <= XW'(signed'({1'b0, t16})) * XW'(dv_abx[T_BITS]);
      m1_py  <= XW'(signed'({1'b0, t16})) * XW'(dv_aby[T_BITS]);
    end
  end

  // Offset from the nearest point and its magnitude, with far-pixel saturation.
  logic signed [XW-1:0] dxq, dyq;
  logic [XW-1:0]        mgx, mgy;
  logic                 m2_v, m2_off, m2_sat;
  logic [31:0]          m2_dst;
  logic [30:0]          m2_mx, m2_my;

  always_comb begin
    dxq = (XW'(m1_apx) <<< T_BITS) - m1_px;
    dyq = (XW'(m1_apy) <<< T_BITS) - m1_py;
    mgx = dxq[XW-1] ? XW'(-dxq) : XW'(dxq);
    mgy = dyq[XW-1] ? XW'(-dyq) : XW'(dyq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (en) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_dst <= m1_dst;
      m2_off <= m1_off;
      m2_sat <= (mgx[XW-1:31] != '0) || (mgy[XW-1:31] != '0);
      m2_mx  <= mgx[30:0];
      m2_my  <= mgy[30:0];
    end
  end

  // Squares of the offsets.
  logic        m3_v, m3_off, m3_sat;
  logic [31:0] m3_dst;
  logic [61:0] m3_sx, m3_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (en) begin
      m3_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_dst <= m2_dst;
      m3_off <= m2_off;
      m3_sat <= m2_sat;
      m3_sx  <= 62'(m2_mx) * 62'(m2_mx);
      m3_sy  <= 62'(m2_my) * 62'(m2_my);
    end
  end

  // Square root segment: index 0 holds the radicand, then one result bit a stage.
  logic          sq_v   [0:NS];
  logic [31:0]   sq_dst [0:NS];
  logic          sq_off [0:NS];
  logic          sq_sat [0:NS];
  logic [SW-1:0] sq_op  [0:NS];
  logic [SW-1:0] sq_res [0:NS];
  logic [62:0]   sqsum;

  assign sqsum = 63'(m3_sx) + 63'(m3_sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_dst[0] <= m3_dst;
      sq_off[0] <= m3_off;
      sq_sat[0] <= m3_sat;
      sq_op[0]  <= sqsum[62:18];
      sq_res[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_sqrt
    localparam logic [SW:0] ONE = (SW+1)'(1) << (2 * (NS - k));
    logic [SW:0] trial;
    logic        take;
    always_comb begin
      trial = {1'b0, sq_res[k-1]} + ONE;
      take  = ({1'b0, sq_op[k-1]} >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= sq_v[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_dst[k] <= sq_dst[k-1];
        sq_off[k] <= sq_off[k-1];
        sq_sat[k] <= sq_sat[k-1];
        if (take) begin
          sq_op[k]  <= SW'({1'b0, sq_op[k-1]} - trial);
          sq_res[k] <= SW'({1'b0, sq_res[k-1] >> 1} + ONE);
        end else begin
          sq_op[k]  <= sq_op[k-1];
          sq_res[k] <= sq_res[k-1] >> 1;
        end
      end
    end
  end

  // Coverage weight against the stroke edge.
  logic [15:0] d88, edge88, wfull;
  logic [8:0]  eff;
  logic        w_v, w_pass, w_full;
  logic [31:0] w_dst;
  logic [7:0]  w_wt;

  always_comb begin
    if (sq_sat[NS] || (sq_res[NS][SW-1:16] != '0)) begin
      d88 = 16'hFFFF;
    end else begin
      d88 = sq_res[NS][15:0];
    end
    if (stroke_width < MIN_STROKE) begin
      eff = 9'(MIN_STROKE);
    end else if (9'(stroke_width) > MAXW) begin
      eff = MAXW;
    end else begin
      eff = 9'(stroke_width);
    end
    edge88 = {eff[8:0], 7'b0} + 16'd128;
    wfull  = edge88 - d88;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v <= 1'b0;
    end else if (en) begin
      w_v <= sq_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_dst  <= sq_dst[NS];
      w_pass <= sq_off[NS] || (d88 >= edge88);
      w_full <= (wfull[15:8] != '0);
      w_wt   <= wfull[7:0];
    end
  end

  // Channel products for a partial blend.
  logic        b_v, b_pass, b_full;
  logic [31:0] b_dst;
  logic [7:0]  b_wt;
  logic [15:0] b_fp [0:2];
  logic [15:0] b_dp [0:2];
  logic [8:0]  iw;

  assign iw = FULL_WEIGHT - 9'(w_wt);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= w_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dst  <= w_dst;
      b_pass <= w_pass;
      b_full <= w_full;
      b_wt   <= w_wt;
      for (int c = 0; c < 3; c++) begin
        b_fp[c] <= 16'(fore_rgb[8*c +: 8]) * 16'(w_wt);
        b_dp[c] <= 16'(w_dst[8*c +: 8]) * 16'(iw);
      end
    end
  end

  // Output register.
  out_t        res;
  logic [15:0] csum [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = b_fp[c] + b_dp[c];
    end
    if (b_pass) begin
      res.out_pixel    = b_dst;
      res.covered      = 1'b0;
      res.blend_weight = '0;
    end else if (b_full) begin
      res.out_pixel    = ALPHA_OPAQUE | {8'h00, fore_rgb};
      res.covered      = 1'b1;
      res.blend_weight = FULL_WEIGHT;
    end else begin
      res.out_pixel    = ALPHA_OPAQUE | {8'h00, csum[2][15:8], csum[1][15:8], csum[0][15:8]};
      res.covered      = 1'b1;
      res.blend_weight = 9'(b_wt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule

// File: sv/thick_line_coverage_blend.sv
// Antialiased thick line pixel shader.
// Configuration: cfg_we writes cfg_data into register cfg_index at a clock
// edge (start_x, start_y, end_x, end_y, stroke_width, fore_rgb, image_cols,
// image_rows); write only while no request is in flight.
// Input channel in_valid/in_ready/in_data carries one pixel request: its
// column, row and current destination ARGB. Output channel
// out_valid/out_ready/out_data returns exactly one result per request, in
// order: the shaded pixel, a covered flag and the blend weight out of 256.
// Throughput is one request per cycle while the output is not stalled.
// The pipeline depth comes mainly from the 16-stage projection divider
// and the 23-stage distance square root.
// A 4-entry queue sits between the geometry front end and the shading
// pipeline. When out_ready is low the shading pipeline holds, the queue
// fills, and in_ready drops once the queue and input register are full.
// Reset (rst, synchronous) empties all stages and restores register
// defaults: endpoints at 0, width 2, black foreground, a 2048x2048 image.
module thick_line_coverage_blend #(
  parameter int COORD_BITS = 12,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tlcb_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tlcb_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [tlcb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tlcb_pkg::*;

  localparam int PW = (COORD_BITS > 12 ? COORD_BITS : 12) + 2;
  localparam int QW = 33 + 8 * PW;

  logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [6:0]  stroke_width;
  logic [23:0] fore_rgb;
  logic [11:0] image_cols, image_rows;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_y      <= '0;
      end_x        <= '0;
      end_y        <= '0;
      stroke_width <= 7'd2;
      fore_rgb     <= '0;
      image_cols   <= 12'd2048;
      image_rows   <= 12'd2048;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_START_X:      start_x      <= cfg_data[COORD_BITS-1:0];
        REG_START_Y:      start_y      <= cfg_data[COORD_BITS-1:0];
        REG_END_X:        end_x        <= cfg_data[COORD_BITS-1:0];
        REG_END_Y:        end_y        <= cfg_data[COORD_BITS-1:0];
        REG_STROKE_WIDTH: stroke_width <= cfg_data[6:0];
        REG_FORE_RGB:     fore_rgb     <= cfg_data[23:0];
        REG_IMAGE_COLS:   image_cols   <= cfg_data[11:0];
        REG_IMAGE_ROWS:   image_rows   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic          q_push, q_full, q_pop, q_not_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  tlcb_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .image_cols (image_cols),
    .image_rows (image_rows),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tlcb_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  tlcb_back #(
    .COORD_BITS(COORD_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .stroke_width (stroke_width),
    .fore_rgb     (fore_rgb),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// File: bench/thick_line_coverage_blend_test.sv
module thick_line_coverage_blend_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlcb_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int MAX_WIDTH  = 64;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  thick_line_coverage_blend uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [11:0] line_x0, line_y0, line_x1, line_y1;
  logic [6:0]  line_width;
  logic [23:0] line_rgb;
  logic [11:0] img_cols, img_rows;

  out_t shaded_q[$];
  int   errors = 0;
  bit   hold_off = 1'b0;
  bit   stall_mode = 1'b1;
  int   burst_max = 8;
  int   gap_max = 4;
  int   burst_left = 0;
  // Set while a sender has left in_valid high between requests.
  bit   paced_hold = 1'b0;

  // Integer square root by bit pairs.
  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned op, res, one;
    op = n;
    res = 0;
    one = 64'd1 << 62;
    while (one > op) one >>= 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  // Expected shading of one pixel under the current configuration.
  function automatic out_t shade_pixel(in_t px);
    out_t r;
    longint ax, ay, bx, by, dp, den, t, ox, oy;
    longint unsigned mx, my, d_len, eff, edge_q, w, iw, f, d;
    r.out_pixel = px.dest_pixel;
    r.covered = 1'b0;
    r.blend_weight = '0;
    if (px.pixel_col >= img_cols || px.pixel_row >= img_rows) return r;
    ax = 2 * (longint'(px.pixel_col) - longint'($signed(line_x0)));
    ay = 2 * (longint'(px.pixel_row) - longint'($signed(line_y0)));
    bx = 2 * (longint'($signed(line_x1)) - longint'($signed(line_x0)));
    by = 2 * (longint'($signed(line_y1)) - longint'($signed(line_y0)));
    dp = ax * bx + ay * by;
    den = bx * bx + by * by;
    if (den == 0 || dp <= 0) t = 0;
    else if (dp >= den) t = 65536;
    else t = longint'((unsigned'(dp) << 16) / unsigned'(den));
    ox = ax * 65536 - t * bx;
    oy = ay * 65536 - t * by;
    mx = ox < 0 ? -ox : ox;
    my = oy < 0 ? -oy : oy;
    if (mx >= (64'd1 << 31) || my >= (64'd1 << 31)) d_len = 16'hFFFF;
    else begin
      d_len = root_of((mx * mx + my * my) >> 18);
      if (d_len > 16'hFFFF) d_len = 16'hFFFF;
    end
    eff = line_width;
    if (eff < 2) eff = 2;
    if (eff > MAX_WIDTH) eff = MAX_WIDTH;
    edge_q = eff * 128 + 128;
    if (d_len >= edge_q) return r;
    w = edge_q - d_len;
    r.covered = 1'b1;
    if (w >= 256) begin
      r.out_pixel = ALPHA_OPAQUE | {8'h00, line_rgb};
      r.blend_weight = FULL_WEIGHT;
      return r;
    end
    iw = 256 - w;
    r.out_pixel = ALPHA_OPAQUE;
    for (int sh = 0; sh <= 16; sh += 8) begin
      f = (line_rgb >> sh) & 8'hFF;
      d = (px.dest_pixel >> sh) & 8'hFF;
      r.out_pixel[sh +: 8] = 8'((f * w + d * iw) >> 8);
    end
    r.blend_weight = 9'(w);
    return r;
  endfunction

  // Register write, only while the pipeline is empty.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_START_X:      line_x0 = val[11:0];
      REG_START_Y:      line_y0 = val[11:0];
      REG_END_X:        line_x1 = val[11:0];
      REG_END_Y:        line_y1 = val[11:0];
      REG_STROKE_WIDTH: line_width = val[6:0];
      REG_FORE_RGB:     line_rgb = val[23:0];
      REG_IMAGE_COLS:   img_cols = val[11:0];
      default:          img_rows = val[11:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop a valid that a sender left high after its last accepted request.
  task automatic release_input();
    if (paced_hold) in_valid <= 1'b0;
    paced_hold = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    release_input();
    while (shaded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_line(int x0, int y0, int x1, int y1, int wd, int rgb,
                          int cols, int rows);
    wait_idle();
    write_reg(REG_START_X, 24'(x0));
    write_reg(REG_START_Y, 24'(y0));
    write_reg(REG_END_X, 24'(x1));
    write_reg(REG_END_Y, 24'(y1));
    write_reg(REG_STROKE_WIDTH, 24'(wd));
    write_reg(REG_FORE_RGB, 24'(rgb));
    write_reg(REG_IMAGE_COLS, 24'(cols));
    write_reg(REG_IMAGE_ROWS, 24'(rows));
  endtask

  // Offer one request at a falling edge and hold it until accepted.
  // Valid stays high afterwards so that requests can follow back to back.
  task automatic send_pixel(int col, int row, logic [31:0] dst);
    in_t px;
    px.pixel_col = 11'(col);
    px.pixel_row = 11'(row);
    px.dest_pixel = dst;
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shaded_q.push_back(shade_pixel(px));
    paced_hold = 1'b1;
    @(negedge clk);
  endtask

  // Bursty sender: a burst of back-to-back requests, then a gap most of the time.
  task automatic send_paced(int col, int row, logic [31:0] dst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      if ($urandom_range(0, 2) != 0) begin
        if (paced_hold) in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{pixel_col: 11'(col), pixel_row: 11'(row), dest_pixel: dst};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shaded_q.push_back(shade_pixel('{11'(col), 11'(row), dst}));
    paced_hold = 1'b1;
    @(negedge clk);
  endtask

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (!stall_mode) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Result checker.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (shaded_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = shaded_q.pop_front();
        if (out_data.out_pixel !== want.out_pixel) begin
          $display("%0t: out_pixel expected %h actual %h", $time,
                   want.out_pixel, out_data.out_pixel);
          errors++;
        end
        if (out_data.covered !== want.covered) begin
          $display("%0t: covered expected %b actual %b", $time,
                   want.covered, out_data.covered);
          errors++;
        end
        if (out_data.blend_weight !== want.blend_weight) begin
          $display("%0t: blend_weight expected %0d actual %0d", $time,
                   want.blend_weight, out_data.blend_weight);
          errors++;
        end
      end
    end
  end

  // Most pixels are picked near the line, the rest anywhere in the image.
  task automatic random_pixel_near();
    int cx, cy, pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      cx = $signed(line_x0) + ($signed(line_x1) - $signed(line_x0))
           * int'($urandom_range(0, 100)) / 100 + int'($urandom_range(0, 40)) - 20;
      cy = $signed(line_y0) + ($signed(line_y1) - $signed(line_y0))
           * int'($urandom_range(0, 100)) / 100 + int'($urandom_range(0, 40)) - 20;
      if (cx < 0) cx = 0;
      if (cx > 2047) cx = 2047;
      if (cy < 0) cy = 0;
      if (cy > 2047) cy = 2047;
    end else begin
      cx = $urandom_range(0, 2047);
      cy = $urandom_range(0, 2047);
    end
    send_paced(cx, cy, $urandom);
  endtask

  task automatic test_directed();
    set_line(10, 10, 40, 25, 6, 24'h3366CC, 2048, 2048);
    send_pixel(0, 0, 32'h0000_0000);
    send_pixel(2047, 2047, 32'hFFFF_FFFF);
    send_pixel(10, 10, 32'h1234_5678);
    send_pixel(40, 25, 32'hA5A5_A5A5);
    send_pixel(25, 17, 32'h5A5A_5A5A);
    for (int k = 0; k < 8; k++) send_pixel(25, 14 + k, 32'h80FF_0080);
    // Degenerate segment, widest stroke, off-image and size zero.
    set_line(-2048, 2047, -2048, 2047, 127, 24'hFFFFFF, 1, 1);
    send_pixel(0, 0, 32'h0102_0304);
    send_pixel(1, 0, 32'hDEAD_BEEF);
    send_pixel(0, 1, 32'hCAFE_F00D);
    set_line(5, 5, 5, 5, 0, 24'hFF00FF, 0, 0);
    send_pixel(5, 5, 32'h1111_1111);
    set_line(5, 5, 5, 5, 0, 24'hFF00FF, 2048, 2048);
    for (int k = 3; k < 8; k++) send_pixel(k, 5, 32'h00FF_00FF);
    set_line(2047, -2048, -2048, 2047, 64, 24'h00FF00, 2048, 2048);
    send_pixel(0, 0, 32'hFFFF_FFFF);
    send_pixel(1024, 1000, 32'h0000_0000);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      int wd, n;
      wd = (ph % 3 == 0) ? 2 : (ph % 3 == 1) ? $urandom_range(0, 127) : 64;
      set_line($urandom_range(0, 300) - 50, $urandom_range(0, 300) - 50,
               $urandom_range(0, 300) - 50, $urandom_range(0, 300) - 50,
               wd, $urandom, (ph == 4) ? 100 : $urandom_range(1, 2048),
               (ph == 4) ? 2048 : $urandom_range(1, 2048));
      burst_max = $urandom_range(1, 16);
      gap_max = $urandom_range(1, 8);
      stall_mode = (ph % 4 != 3);
      n = 100;
      for (int i = 0; i < n; i++) random_pixel_near();
    end
  endtask

  task automatic test_backpressure();
    set_line(0, 0, 60, 30, 10, 24'h8040C0, 2048, 2048);
    stall_mode = 1'b0;
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_pixel($urandom_range(0, 70),
                                              $urandom_range(0, 40), $urandom);
    join
    release_input();
    // Sender pauses until every expected result is in.
    while (shaded_q.size() != 0) @(negedge clk);
    stall_mode = 1'b1;
    for (int i = 0; i < 30; i++) random_pixel_near();
  endtask

  initial begin
    rst = 1'b1;
    line_x0 = 0; line_y0 = 0; line_x1 = 0; line_y1 = 0;
    line_width = 2; line_rgb = 0; img_cols = 2048; img_rows = 2048;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    release_input();
    while (shaded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
